// ----- hw/rtl/tdl_pkg.sv -----
`timescale 1ns / 1ps
package tdl_pkg;

  localparam int MAX_NODES = 32;
  localparam int NODE_W    = 5;
  localparam int CNT_W     = 6;
  localparam int ARC_W     = 10;
  localparam int VAL_W     = 32;
  localparam int FLOW_W    = 40;
  localparam int TOT_W     = 64;
  localparam int FRAC_BITS = 16;
  localparam int ERR_W     = 2;

  localparam logic [ERR_W-1:0] ERR_OK      = 2'd0;
  localparam logic [ERR_W-1:0] ERR_ZONE    = 2'd1;
  localparam logic [ERR_W-1:0] ERR_UNREACH = 2'd2;

  localparam logic KIND_ARC = 1'b0;
  localparam logic KIND_SUM = 1'b1;

  localparam logic REG_ORIGIN = 1'b0;
  localparam logic REG_ZONES  = 1'b1;

  typedef struct packed {
    logic              valid;
    logic [NODE_W-1:0] node;
    logic [ARC_W-1:0]  arc;
  } tree_entry_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // take a node request
    logic acc;      // add cost term
    logic init;     // start tree build
    logic tstart;   // begin trace of node i
    logic push;     // push cur, mark it, read its tree entry
    logic follow;   // step to predecessor
    logic pop_rd;   // read top of trace stack
    logic pop_wr;   // append to order
    logic next_i;   // next trace root
    logic s_rd;     // read order entry
    logic s_cur;    // read tree and remaining of cur
    logic s_act;    // push flow or flag error
    logic s_addrd;  // read remaining of predecessor
    logic s_addwr;  // write remaining of predecessor
    logic summ;     // emit summary, end run
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last;
    logic labeled;
    logic pos_full;
    logic pos_zero;
    logic i_last;
    logic j_le1;
    logic is_origin;
    logic valid_eff;
  } ctrl_sts_t;

endpackage

// ----- hw/rtl/tdl_ctrl.sv -----
`timescale 1ns / 1ps
module tdl_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  tdl_pkg::ctrl_sts_t sts_i,
  output tdl_pkg::ctrl_cmd_t cmd_o
);
  import tdl_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ACC   = 4'd1;
  localparam logic [3:0] S_CINIT = 4'd2;
  localparam logic [3:0] S_TSTRT = 4'd3;
  localparam logic [3:0] S_TCHK  = 4'd4;
  localparam logic [3:0] S_TFOL  = 4'd5;
  localparam logic [3:0] S_PRD   = 4'd6;
  localparam logic [3:0] S_PWR   = 4'd7;
  localparam logic [3:0] S_NEXTI = 4'd8;
  localparam logic [3:0] S_SRD   = 4'd9;
  localparam logic [3:0] S_SCUR  = 4'd10;
  localparam logic [3:0] S_SACT  = 4'd11;
  localparam logic [3:0] S_SADDR = 4'd12;
  localparam logic [3:0] S_SADDW = 4'd13;
  localparam logic [3:0] S_SUMM  = 4'd14;

  logic [3:0] state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_ACC;
        end
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = sts_i.last ? S_CINIT : S_IDLE;
      end
      S_CINIT: begin
        cmd_o.init = 1'b1;
        state_d    = S_TSTRT;
      end
      S_TSTRT: begin
        cmd_o.tstart = 1'b1;
        state_d      = S_TCHK;
      end
      S_TCHK: begin
        if (sts_i.labeled || sts_i.pos_full) begin
          state_d = S_PRD;
        end else begin
          cmd_o.push = 1'b1;
          state_d    = S_TFOL;
        end
      end
      S_TFOL: begin
        cmd_o.follow = 1'b1;
        state_d      = S_TCHK;
      end
      S_PRD: begin
        if (sts_i.pos_zero) begin
          state_d = S_NEXTI;
        end else begin
          cmd_o.pop_rd = 1'b1;
          state_d      = S_PWR;
        end
      end
      S_PWR: begin
        cmd_o.pop_wr = 1'b1;
        state_d      = S_PRD;
      end
      S_NEXTI: begin
        cmd_o.next_i = 1'b1;
        state_d      = sts_i.i_last ? S_SRD : S_TSTRT;
      end
      S_SRD: begin
        if (sts_i.j_le1) begin
          state_d = S_SUMM;
        end else begin
          cmd_o.s_rd = 1'b1;
          state_d    = S_SCUR;
        end
      end
      S_SCUR: begin
        if (sts_i.is_origin) begin
          state_d = S_SUMM;
        end else begin
          cmd_o.s_cur = 1'b1;
          state_d     = S_SACT;
        end
      end
      S_SACT: begin
        cmd_o.s_act = 1'b1;
        state_d     = sts_i.valid_eff ? S_SADDR : S_SRD;
      end
      S_SADDR: begin
        cmd_o.s_addrd = 1'b1;
        state_d       = S_SADDW;
      end
      S_SADDW: begin
        cmd_o.s_addwr = 1'b1;
        state_d       = S_SRD;
      end
      S_SUMM: begin
        cmd_o.summ = 1'b1;
        state_d    = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ----- hw/rtl/tdl_dp.sv -----
`timescale 1ns / 1ps
module tdl_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tdl_pkg::ctrl_cmd_t           cmd_i,
  output tdl_pkg::ctrl_sts_t           sts_o,
  input  logic [tdl_pkg::NODE_W-1:0]   origin_i,
  input  logic [tdl_pkg::CNT_W-1:0]    zones_i,
  input  logic                         has_pred_i,
  input  logic [tdl_pkg::NODE_W-1:0]   pred_node_i,
  input  logic [tdl_pkg::ARC_W-1:0]    pred_arc_i,
  input  logic [tdl_pkg::VAL_W-1:0]    path_cost_i,
  input  logic [tdl_pkg::VAL_W-1:0]    demand_i,
  input  logic                         last_node_i,
  output logic                         res_valid_o,
  output logic                         kind_o,
  output logic [tdl_pkg::ARC_W-1:0]    arc_index_o,
  output logic [tdl_pkg::FLOW_W-1:0]   flow_added_o,
  output logic [tdl_pkg::TOT_W-1:0]    path_time_total_o,
  output logic [tdl_pkg::ERR_W-1:0]    error_code_o,
  output logic                         last_result_o
);
  import tdl_pkg::*;

  tree_entry_t       tree_mem  [MAX_NODES];
  logic [FLOW_W-1:0] rem_mem   [MAX_NODES];
  logic [NODE_W-1:0] order_mem [MAX_NODES];
  logic [NODE_W-1:0] trace_mem [MAX_NODES];

  tree_entry_t       tree_rd_q;
  logic [FLOW_W-1:0] rem_rd_q, v_q;
  logic [NODE_W-1:0] order_rd_q, trace_rd_q, cur_q;

  logic [CNT_W-1:0]     cnt_q, i_q, pos_q, ord_q, j_q;
  logic [MAX_NODES-1:0] labeled_q;
  logic [2*VAL_W-1:0]   prod_q;
  logic                 add_q, last_q, zone_err_q;
  logic [TOT_W-1:0]     total_q;
  logic [ERR_W-1:0]     err_q;

  logic                 room, is_zone;
  logic [TOT_W:0]       sum;
  logic                 valid_eff;
  logic                 rem_we;
  logic [NODE_W-1:0]    rem_wa, rem_ra, tree_ra;
  logic [FLOW_W-1:0]    rem_wd;
  logic [CNT_W-1:0]     pos_m1, j_m1, i_p1;

  assign room      = !cnt_q[CNT_W-1];
  assign is_zone   = cnt_q < zones_i;
  assign sum       = {1'b0, total_q} + {{(FRAC_BITS+1){1'b0}}, prod_q[2*VAL_W-1:FRAC_BITS]};
  // predecessor outside this run counts as none
  assign valid_eff = tree_rd_q.valid && ({1'b0, tree_rd_q.node} < cnt_q);
  assign pos_m1    = pos_q - CNT_W'(1);
  assign j_m1      = j_q - CNT_W'(1);
  assign i_p1      = i_q + CNT_W'(1);

  assign tree_ra = cmd_i.s_cur ? order_rd_q : cur_q;
  assign rem_ra  = cmd_i.s_cur ? order_rd_q : tree_rd_q.node;

  always_comb begin
    rem_we = 1'b0;
    rem_wa = cnt_q[NODE_W-1:0];
    rem_wd = is_zone ? {{(FLOW_W-VAL_W){1'b0}}, demand_i} : '0;
    if (cmd_i.load) begin
      rem_we = room;
    end else if (cmd_i.s_act) begin
      rem_we = 1'b1;
      rem_wa = cur_q;
      rem_wd = '0;
    end else if (cmd_i.s_addwr) begin
      rem_we = 1'b1;
      rem_wa = tree_rd_q.node;
      rem_wd = rem_rd_q + v_q;
    end
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && room) begin
      tree_mem[cnt_q[NODE_W-1:0]] <= '{valid: has_pred_i, node: pred_node_i, arc: pred_arc_i};
    end
    if (rem_we) rem_mem[rem_wa] <= rem_wd;
    if (cmd_i.push) trace_mem[pos_q[NODE_W-1:0]] <= cur_q;
    if (cmd_i.pop_wr) order_mem[ord_q[NODE_W-1:0]] <= trace_rd_q;
    if (cmd_i.push || cmd_i.s_cur) tree_rd_q <= tree_mem[tree_ra];
    if (cmd_i.s_cur || cmd_i.s_addrd) rem_rd_q <= rem_mem[rem_ra];
    if (cmd_i.pop_rd) trace_rd_q <= trace_mem[pos_m1[NODE_W-1:0]];
    if (cmd_i.s_rd) order_rd_q <= order_mem[j_m1[NODE_W-1:0]];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) prod_q <= path_cost_i * demand_i;
    if (cmd_i.tstart) cur_q <= i_q[NODE_W-1:0];
    if (cmd_i.follow && valid_eff) cur_q <= tree_rd_q.node;
    if (cmd_i.s_cur) cur_q <= order_rd_q;
    if (cmd_i.s_act) v_q <= rem_rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q             <= '0;
      i_q               <= '0;
      pos_q             <= '0;
      ord_q             <= '0;
      j_q               <= '0;
      labeled_q         <= '0;
      add_q             <= 1'b0;
      last_q            <= 1'b0;
      zone_err_q        <= 1'b0;
      total_q           <= '0;
      err_q             <= ERR_OK;
      res_valid_o       <= 1'b0;
      kind_o            <= KIND_ARC;
      arc_index_o       <= '0;
      flow_added_o      <= '0;
      path_time_total_o <= '0;
      error_code_o      <= ERR_OK;
      last_result_o     <= 1'b0;
    end else begin
      res_valid_o <= 1'b0;
      if (cmd_i.load) begin
        last_q <= last_node_i;
        add_q  <= room && is_zone && has_pred_i;
        if (room) begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (is_zone && !has_pred_i && (demand_i != '0)
              && (cnt_q[NODE_W-1:0] != origin_i)) begin
            zone_err_q <= 1'b1;
          end
        end
      end
      if (cmd_i.acc && add_q) begin
        total_q <= sum[TOT_W] ? '1 : sum[TOT_W-1:0];
      end
      if (cmd_i.init) begin
        labeled_q <= '0;
        i_q       <= '0;
        ord_q     <= '0;
        err_q     <= zone_err_q ? ERR_ZONE : ERR_OK;
      end
      if (cmd_i.tstart) pos_q <= '0;
      if (cmd_i.push) begin
        labeled_q[cur_q] <= 1'b1;
        pos_q            <= pos_q + CNT_W'(1);
      end
      if (cmd_i.pop_rd) pos_q <= pos_m1;
      if (cmd_i.pop_wr) ord_q <= ord_q + CNT_W'(1);
      if (cmd_i.next_i) begin
        i_q <= i_p1;
        j_q <= ord_q;
      end
      if (cmd_i.s_act) begin
        j_q <= j_m1;
        if (valid_eff) begin
          res_valid_o       <= 1'b1;
          kind_o            <= KIND_ARC;
          arc_index_o       <= tree_rd_q.arc;
          flow_added_o      <= rem_rd_q;
          path_time_total_o <= '0;
          error_code_o      <= ERR_OK;
          last_result_o     <= 1'b0;
        end else if ((rem_rd_q != '0) && (err_q == ERR_OK)) begin
          err_q <= ERR_UNREACH;
        end
      end
      if (cmd_i.summ) begin
        res_valid_o       <= 1'b1;
        kind_o            <= KIND_SUM;
        arc_index_o       <= '0;
        flow_added_o      <= '0;
        path_time_total_o <= total_q;
        error_code_o      <= err_q;
        last_result_o     <= 1'b1;
        cnt_q             <= '0;
        total_q           <= '0;
        zone_err_q        <= 1'b0;
      end
    end
  end

  assign sts_o.last      = last_q;
  assign sts_o.labeled   = labeled_q[cur_q];
  assign sts_o.pos_full  = pos_q[CNT_W-1];
  assign sts_o.pos_zero  = (pos_q == '0);
  assign sts_o.i_last    = (i_p1 == cnt_q);
  assign sts_o.j_le1     = (j_q <= CNT_W'(1));
  assign sts_o.is_origin = (order_rd_q == origin_i);
  assign sts_o.valid_eff = valid_eff;

  a_push_unlabeled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> !labeled_q[cur_q])
    else $error("push of a labeled node");

  a_run_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.summ |=> (cnt_q == '0) && (total_q == '0) && !zone_err_q)
    else $error("run state not cleared after summary");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= CNT_W'(MAX_NODES))
    else $error("trace stack overflow");

  a_order_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop_wr |-> !ord_q[CNT_W-1])
    else $error("order overflow");

endmodule

// ----- hw/rtl/tree_demand_loader.sv -----
`timescale 1ns / 1ps
// Tree demand loader: loads one origin's shortest-path tree and pushes its demand
// onto the tree arcs.
// Input: one node request per start pulse, taken when start_i is high and busy_o low.
//   Nodes are numbered from 0 in arrival order; last_node_i marks the final one.
//   Each node request is multiplied at accept and added, saturating, in the next cycle.
// After the last node the block builds a topological order (each node is traced as
//   a root; each unlabeled node on its path is pushed onto and popped off the
//   trace stack) and then sweeps the order in reverse, pushing each remaining
//   demand onto its tree arc, or flagging it unreachable if it has no predecessor.
// Output: result_valid_o is high for exactly one cycle per result; kind_o = 0 is an
//   arc result, kind_o = 1 the closing summary with last_result_o set. The receiver
//   cannot stall; results are simply presented one at a time.
// Config: APB, origin at 0x0, zone count at 0x4; write only while busy_o is low.
// Reset: asynchronous, clears counters, totals, errors and config registers; the
//   per-node tables need no clearing pass since a run writes each entry before use.
module tree_demand_loader (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic                       has_pred_i,
  input  logic [tdl_pkg::NODE_W-1:0] pred_node_i,
  input  logic [tdl_pkg::ARC_W-1:0]  pred_arc_i,
  input  logic [tdl_pkg::VAL_W-1:0]  path_cost_i,
  input  logic [tdl_pkg::VAL_W-1:0]  demand_i,
  input  logic                       last_node_i,
  output logic                       result_valid_o,
  output logic                       kind_o,
  output logic [tdl_pkg::ARC_W-1:0]  arc_index_o,
  output logic [tdl_pkg::FLOW_W-1:0] flow_added_o,
  output logic [tdl_pkg::TOT_W-1:0]  path_time_total_o,
  output logic [tdl_pkg::ERR_W-1:0]  error_code_o,
  output logic                       last_result_o
);
  import tdl_pkg::*;

  logic [NODE_W-1:0] origin_q;
  logic [CNT_W-1:0]  zones_q;
  ctrl_cmd_t         cmd;
  ctrl_sts_t         sts;

  assign pready = 1'b1;

  // register index is the word address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q <= '0;
      zones_q  <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_ORIGIN) begin
        origin_q <= pwdata[NODE_W-1:0];
      end else begin
        zones_q <= pwdata[CNT_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_ZONES) ? {{(32-CNT_W){1'b0}}, zones_q}
                                          : {{(32-NODE_W){1'b0}}, origin_q};

  tdl_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  tdl_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .origin_i         (origin_q),
    .zones_i          (zones_q),
    .has_pred_i       (has_pred_i),
    .pred_node_i      (pred_node_i),
    .pred_arc_i       (pred_arc_i),
    .path_cost_i      (path_cost_i),
    .demand_i         (demand_i),
    .last_node_i      (last_node_i),
    .res_valid_o      (result_valid_o),
    .kind_o           (kind_o),
    .arc_index_o      (arc_index_o),
    .flow_added_o     (flow_added_o),
    .path_time_total_o(path_time_total_o),
    .error_code_o     (error_code_o),
    .last_result_o    (last_result_o)
  );

endmodule
